// ===== src/step_sequencer_pulse_scheduler_core_macros.svh =====
// Assertion macros for the step sequencer pulse scheduler
`ifndef STEP_SEQUENCER_PULSE_SCHEDULER_CORE_MACROS_SVH
`define STEP_SEQUENCER_PULSE_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sps_pkg.sv =====
// Shared constants, types and codes for the step sequencer pulse scheduler
`default_nettype none

package sps_pkg;

    localparam int STEPS           = 16;
    localparam int PULSES_PER_STEP = 6;
    localparam int TRACKS          = 16;
    localparam int MAX_RESULTS     = 64;
    localparam int QDEPTH          = 2;

    localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int PH_W     = (PULSES_PER_STEP > 1) ? $clog2(PULSES_PER_STEP) : 1;
    localparam int TRK_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int QP_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W     = $clog2(QDEPTH + 1);
    localparam int DIV_BITS = 33;
    localparam int DIV_CW   = $clog2(DIV_BITS + 1);

    localparam logic [15:0] SPP_RESET = 16'd918;

    typedef enum logic [1:0] {
        OP_TOGGLE  = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_STOP    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_TOGGLE,
        CMD_ADVANCE,
        CMD_STOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [TRK_W-1:0]   track;
        logic [STEP_W-1:0]  step;
        logic [31:0]        pos;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MOD,
        B_PREP,
        B_DIV,
        B_COUNT,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [15:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [31:0]       quotient;
        logic [15:0]       remainder;
        logic [STEP_W-1:0] n_step;
        logic [PH_W-1:0]   n_phase;
    } div_res_t;

endpackage

`default_nettype wire

// ===== src/sps_if.sv =====
// Item channel interfaces for the step sequencer pulse scheduler
`default_nettype none

interface sps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  track_index;
    logic [3:0]  step_index;
    logic [31:0] transport_pos;

    modport source (output valid, output operation, output track_index,
                    output step_index, output transport_pos, input ready);
    modport sink   (input valid, input operation, input track_index,
                    input step_index, input transport_pos, output ready);
endinterface

interface sps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] event_sample;
    logic [15:0] track_mask;
    logic [3:0]  event_step;
    logic        overflow;
    logic        last;

    modport source (output valid, output event_sample, output track_mask,
                    output event_step, output overflow, output last, input ready);
    modport sink   (input valid, input event_sample, input track_mask,
                    input event_step, input overflow, input last, output ready);
endinterface

`default_nettype wire

// ===== src/sps_front.sv =====
// Front end: accept input items, classify them and drop those that do nothing
`default_nettype none

module sps_front (
    sps_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          q_push,
    output sps_pkg::cmd_t q_cmd
);
    import sps_pkg::*;

    logic keep;

    assign in_ch.ready = !q_full;

    always_comb
    begin
        keep        = 1'b0;
        q_cmd.kind  = CMD_ADVANCE;
        q_cmd.track = TRK_W'(in_ch.track_index);
        q_cmd.step  = STEP_W'(in_ch.step_index);
        q_cmd.pos   = in_ch.transport_pos;
        case (in_ch.operation)
            OP_TOGGLE:
            begin
                q_cmd.kind = CMD_TOGGLE;
                keep = (int'(in_ch.track_index) < TRACKS) && (int'(in_ch.step_index) < STEPS);
            end
            OP_ADVANCE:
            begin
                q_cmd.kind = CMD_ADVANCE;
                keep = 1'b1;
            end
            OP_STOP:
            begin
                q_cmd.kind = CMD_STOP;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = in_ch.valid && !q_full && keep;

endmodule

`default_nettype wire

// ===== src/sps_fifo.sv =====
// Short command queue between the front end and the back end
`default_nettype none

module sps_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sps_pkg::cmd_t push_cmd,
    input  logic          pop,
    output sps_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    import sps_pkg::*;

    cmd_t            mem_reg [QDEPTH];
    logic [QP_W-1:0] wptr_reg, wptr_next;
    logic [QP_W-1:0] rptr_reg, rptr_next;
    logic [QC_W-1:0] fill_reg, fill_next;

    assign full     = (fill_reg == QC_W'(QDEPTH));
    assign empty    = (fill_reg == '0);
    assign head_cmd = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wptr_reg + QP_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rptr_reg + QP_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + QC_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/sps_div.sv =====
// Serial restoring divider, one quotient bit a cycle, with quotient folded mod the pulse cycle
`default_nettype none

module sps_div (
    input  logic               clk,
    input  logic               rst_n,
    input  sps_pkg::div_req_t  req,
    output sps_pkg::div_stat_t stat,
    output sps_pkg::div_res_t  res
);
    import sps_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [15:0]         rem_reg, rem_next;
    logic [15:0]         dvs_reg, dvs_next;
    logic [STEP_W-1:0]   nstep_reg, nstep_next;
    logic [PH_W-1:0]     nphase_reg, nphase_next;

    logic [16:0]         trial;
    logic [16:0]         diff;
    logic                ge;
    logic [PH_W:0]       ph2;
    logic                carry;
    logic [STEP_W:0]     st2;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        nstep_next  = nstep_reg;
        nphase_next = nphase_reg;

        trial = {rem_reg, quo_reg[DIV_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
        ph2   = {nphase_reg, ge};
        carry = (ph2 >= (PH_W + 1)'(PULSES_PER_STEP));
        if (carry)
        begin
            ph2 = ph2 - (PH_W + 1)'(PULSES_PER_STEP);
        end
        st2 = {nstep_reg, carry};
        if (st2 >= (STEP_W + 1)'(STEPS))
        begin
            st2 = st2 - (STEP_W + 1)'(STEPS);
        end

        if (req.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = DIV_CW'(DIV_BITS);
            quo_next    = req.dividend;
            rem_next    = '0;
            dvs_next    = req.divisor;
            nstep_next  = '0;
            nphase_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next    = ge ? diff[15:0] : trial[15:0];
            quo_next    = {quo_reg[DIV_BITS-2:0], ge};
            nphase_next = ph2[PH_W-1:0];
            nstep_next  = st2[STEP_W-1:0];
            cnt_next    = cnt_reg - DIV_CW'(1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        nstep_reg  <= nstep_next;
        nphase_reg <= nphase_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign res.quotient  = quo_reg[31:0];
    assign res.remainder = rem_reg;
    assign res.n_step    = nstep_reg;
    assign res.n_phase   = nphase_reg;

endmodule

`default_nettype wire

// ===== src/sps_back.sv =====
// Back end: pattern, transport state, boundary walk and the result register
`default_nettype none

module sps_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  sps_pkg::cmd_t      q_cmd,
    input  logic               q_empty,
    output logic               q_pop,
    output sps_pkg::div_req_t  div_req,
    input  sps_pkg::div_stat_t div_stat,
    input  sps_pkg::div_res_t  div_res,
    sps_out_if.source          out_ch
);
    import sps_pkg::*;

    back_state_t       state_reg, state_next;
    logic [15:0]       spp_reg, spp_next;
    logic [TRACKS-1:0] pattern_reg [STEPS];
    logic [TRACKS-1:0] pattern_next [STEPS];
    logic [31:0]       pos_reg, pos_next;
    logic [STEP_W-1:0] pc_step_reg, pc_step_next;
    logic [PH_W-1:0]   pc_phase_reg, pc_phase_next;

    logic [31:0]       newpos_reg, newpos_next;
    logic [32:0]       start_reg, start_next;
    logic [31:0]       n_reg, n_next;
    logic [31:0]       stride_reg, stride_next;
    logic [32:0]       k_reg, k_next;
    logic [31:0]       sample_reg, sample_next;
    logic [STEP_W-1:0] wstep_reg, wstep_next;
    logic [PH_W-1:0]   init_k_reg, init_k_next;
    logic [31:0]       init_sample_reg, init_sample_next;
    logic [STEP_W-1:0] init_step_reg, init_step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic              ovf_reg, ovf_next;

    logic              ov_reg, ov_next;
    logic [31:0]       o_sample_reg, o_sample_next;
    logic [15:0]       o_mask_reg, o_mask_next;
    logic [3:0]        o_step_reg, o_step_next;
    logic              o_ovf_reg, o_ovf_next;
    logic              o_last_reg, o_last_next;

    logic [15:0]       spp_eff;
    logic [TRACKS-1:0] mask_cur;
    logic              fire;
    logic              pat_any;
    logic              out_free;
    logic [PH_W-1:0]   k0;
    logic [STEP_W-1:0] step0;
    logic [PH_W:0]     ph_sum;
    logic              ph_carry;
    logic [STEP_W:0]   st_sum;

    function automatic logic [STEP_W-1:0] step_inc(input logic [STEP_W-1:0] s);
        step_inc = (s == STEP_W'(STEPS - 1)) ? '0 : s + STEP_W'(1);
    endfunction

    assign spp_eff  = (spp_reg == '0) ? 16'd1 : spp_reg;
    assign mask_cur = pattern_reg[wstep_reg];
    assign fire     = |mask_cur;
    assign out_free = !ov_reg || out_ch.ready;

    always_comb
    begin
        pat_any = 1'b0;
        for (int i = 0; i < STEPS; i++)
        begin
            pat_any = pat_any | (|pattern_reg[i]);
        end
    end

    always_comb
    begin
        k0    = (pc_phase_reg == '0) ? '0 : PH_W'(PULSES_PER_STEP) - pc_phase_reg;
        step0 = (pc_phase_reg == '0) ? pc_step_reg : step_inc(pc_step_reg);

        ph_sum   = (PH_W + 1)'(pc_phase_reg) + (PH_W + 1)'(div_res.n_phase);
        ph_carry = (ph_sum >= (PH_W + 1)'(PULSES_PER_STEP));
        if (ph_carry)
        begin
            ph_sum = ph_sum - (PH_W + 1)'(PULSES_PER_STEP);
        end
        st_sum = (STEP_W + 1)'(pc_step_reg) + (STEP_W + 1)'(div_res.n_step)
                 + (STEP_W + 1)'(ph_carry);
        if (st_sum >= (STEP_W + 1)'(STEPS))
        begin
            st_sum = st_sum - (STEP_W + 1)'(STEPS);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        spp_next         = cfg_we ? cfg_wdata : spp_reg;
        pattern_next     = pattern_reg;
        pos_next         = pos_reg;
        pc_step_next     = pc_step_reg;
        pc_phase_next    = pc_phase_reg;
        newpos_next      = newpos_reg;
        start_next       = start_reg;
        n_next           = n_reg;
        stride_next      = stride_reg;
        k_next           = k_reg;
        sample_next      = sample_reg;
        wstep_next       = wstep_reg;
        init_k_next      = init_k_reg;
        init_sample_next = init_sample_reg;
        init_step_next   = init_step_reg;
        cnt_next         = cnt_reg;
        emit_next        = emit_reg;
        ovf_next         = ovf_reg;
        ov_next          = ov_reg && !out_ch.ready;
        o_sample_next    = o_sample_reg;
        o_mask_next      = o_mask_reg;
        o_step_next      = o_step_reg;
        o_ovf_next       = o_ovf_reg;
        o_last_next      = o_last_reg;
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, pos_reg};
        div_req.divisor  = spp_eff;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_TOGGLE:
                        begin
                            for (int i = 0; i < STEPS; i++)
                            begin
                                if (STEP_W'(i) == q_cmd.step)
                                begin
                                    pattern_next[i] = pattern_reg[i]
                                                      ^ (TRACKS'(1) << q_cmd.track);
                                end
                            end
                        end
                        CMD_STOP:
                        begin
                            pos_next      = '0;
                            pc_step_next  = '0;
                            pc_phase_next = '0;
                        end
                        CMD_ADVANCE:
                        begin
                            newpos_next   = q_cmd.pos;
                            div_req.start = 1'b1;
                            state_next    = B_MOD;
                        end
                        default:
                        begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_MOD:
            begin
                if (div_stat.done)
                begin
                    start_next = (div_res.remainder == '0) ? {1'b0, pos_reg}
                                 : {1'b0, pos_reg} + 33'(spp_eff) - 33'(div_res.remainder);
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                pos_next    = newpos_reg;
                stride_next = 32'(spp_eff) * 32'(PULSES_PER_STEP);
                if ({1'b0, newpos_reg} > start_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, newpos_reg} - start_reg + 33'(spp_eff) - 33'd1;
                    state_next       = B_DIV;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_DIV:
            begin
                if (div_stat.done)
                begin
                    n_next           = div_res.quotient;
                    init_k_next      = k0;
                    init_step_next   = step0;
                    init_sample_next = start_reg[31:0] + 32'(32'(k0) * 32'(spp_eff));
                    k_next           = 33'(k0);
                    wstep_next       = step0;
                    sample_next      = start_reg[31:0] + 32'(32'(k0) * 32'(spp_eff));
                    cnt_next         = '0;
                    emit_next        = '0;
                    ovf_next         = 1'b0;
                    pc_phase_next    = ph_sum[PH_W-1:0];
                    pc_step_next     = st_sum[STEP_W-1:0];
                    state_next       = B_COUNT;
                end
            end
            B_COUNT:
            begin
                if ((k_reg >= {1'b0, n_reg}) || !pat_any)
                begin
                    k_next      = 33'(init_k_reg);
                    sample_next = init_sample_reg;
                    wstep_next  = init_step_reg;
                    state_next  = (cnt_reg != '0) ? B_EMIT : B_IDLE;
                end
                else
                begin
                    k_next      = k_reg + 33'(PULSES_PER_STEP);
                    sample_next = sample_reg + stride_reg;
                    wstep_next  = step_inc(wstep_reg);
                    if (fire)
                    begin
                        if (cnt_reg == CNT_W'(MAX_RESULTS))
                        begin
                            ovf_next    = 1'b1;
                            k_next      = 33'(init_k_reg);
                            sample_next = init_sample_reg;
                            wstep_next  = init_step_reg;
                            state_next  = B_EMIT;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                end
            end
            B_EMIT:
            begin
                if (!fire || out_free)
                begin
                    k_next      = k_reg + 33'(PULSES_PER_STEP);
                    sample_next = sample_reg + stride_reg;
                    wstep_next  = step_inc(wstep_reg);
                end
                if (fire && out_free)
                begin
                    ov_next       = 1'b1;
                    o_sample_next = sample_reg;
                    o_mask_next   = 16'(mask_cur);
                    o_step_next   = 4'(wstep_reg);
                    o_ovf_next    = ovf_reg;
                    o_last_next   = ((emit_reg + CNT_W'(1)) == cnt_reg);
                    emit_next     = emit_reg + CNT_W'(1);
                    if ((emit_reg + CNT_W'(1)) == cnt_reg)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            spp_reg      <= SPP_RESET;
            pos_reg      <= '0;
            pc_step_reg  <= '0;
            pc_phase_reg <= '0;
            ov_reg       <= 1'b0;
            for (int i = 0; i < STEPS; i++)
            begin
                pattern_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            spp_reg      <= spp_next;
            pos_reg      <= pos_next;
            pc_step_reg  <= pc_step_next;
            pc_phase_reg <= pc_phase_next;
            ov_reg       <= ov_next;
            pattern_reg  <= pattern_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newpos_reg      <= newpos_next;
        start_reg       <= start_next;
        n_reg           <= n_next;
        stride_reg      <= stride_next;
        k_reg           <= k_next;
        sample_reg      <= sample_next;
        wstep_reg       <= wstep_next;
        init_k_reg      <= init_k_next;
        init_sample_reg <= init_sample_next;
        init_step_reg   <= init_step_next;
        cnt_reg         <= cnt_next;
        emit_reg        <= emit_next;
        ovf_reg         <= ovf_next;
        o_sample_reg    <= o_sample_next;
        o_mask_reg      <= o_mask_next;
        o_step_reg      <= o_step_next;
        o_ovf_reg       <= o_ovf_next;
        o_last_reg      <= o_last_next;
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.event_sample = o_sample_reg;
    assign out_ch.track_mask   = o_mask_reg;
    assign out_ch.event_step   = o_step_reg;
    assign out_ch.overflow     = o_ovf_reg;
    assign out_ch.last         = o_last_reg;

endmodule

`default_nettype wire

// ===== src/step_sequencer_pulse_scheduler_core.sv =====
// Toggle and stop are applied in the back end's idle state; an advance runs a 33-bit serial
// division, a second one if the new position passes the next pulse, and two walks of the step
// boundaries crossed, one a cycle: a counting pass, and an emitting pass held by output stalls.
// Throughput: one item at a time in the back end; a two-entry queue keeps input open meanwhile.
// Reset: pattern all off, transport and pulse counter zero, samples_per_pulse 918.
`default_nettype none
`include "step_sequencer_pulse_scheduler_core_macros.svh"

module step_sequencer_pulse_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    sps_in_if.sink      in_ch,
    sps_out_if.source   out_ch
);
    import sps_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    div_req_t  div_req;
    div_stat_t div_stat;
    div_res_t  div_res;

    sps_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    sps_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    sps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat),
        .res   (div_res)
    );

    sps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_cmd     (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_stat  (div_stat),
        .div_res   (div_res),
        .out_ch    (out_ch)
    );

    `SPS_ASSERT_IMP(a_push_room, q_push, !q_full, "item pushed into a full queue")
    `SPS_ASSERT_IMP(a_pop_avail, q_pop, !q_empty, "item popped from an empty queue")
    `SPS_ASSERT_IMP(a_div_idle, div_req.start, !div_stat.busy, "divider restarted while busy")
    `SPS_ASSERT_NXT(a_div_done, div_stat.done, !div_stat.busy && !div_stat.done, "done repeated")

endmodule

`default_nettype wire
